// ----- rtl/tbo_pkg.sv -----
// Package for the triangle / box overlap test: field widths and the
// table that selects the edge, box axis and vertex pair of each edge-axis test.
// Depends on nothing.
package tbo_pkg;

  localparam int CoordW = 24;  // input coordinates, signed Q12.12
  localparam int VecW   = 25;  // translated vertices and edges
  localparam int HalfW  = 23;  // box half extents
  localparam int TolW   = 12;  // edge-test slack
  localparam int CfgW   = 23;  // widest register
  localparam int CfgIdxW = 2;
  localparam int ProdW  = 50;  // product of two vector components
  localparam int CmpW   = 52;  // edge projections and radii
  localparam int NrmW   = 51;  // normal components
  localparam int NrmLoW = 26;  // low part of a split normal component
  localparam int WideW  = 80;  // plane-test accumulators
  localparam int NumEdgeTests = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2,
    REG_TOL    = 2'd3
  } reg_idx_e;

  // Edge index, box axis, and the two vertices projected, per test.
  localparam int EdgeSel[NumEdgeTests] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
  localparam int AxisSel[NumEdgeTests] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
  localparam int VertA[NumEdgeTests]   = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
  localparam int VertB[NumEdgeTests]   = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

  function automatic logic [VecW-1:0] mag_vec(input logic signed [VecW-1:0] a);
    logic [VecW-1:0] r;
    r = a[VecW-1] ? VecW'(-a) : VecW'(a);
    return r;
  endfunction

endpackage

// ----- rtl/triangle_box_overlap_test.sv -----
// Triangle / axis-aligned box overlap by the separating-axis test.
// Seven-stage pipeline with registered result; uses tbo_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o): one beat carries the box center
//   and three triangle vertices, signed Q12.12. Output channel
//   (out_valid_o / out_ready_i): one beat per input beat, overlaps_o = 1 when
//   no separating axis exists. Results leave in input order.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0..2 half sizes x, y, z, 3 tolerance) at a clock edge; write only while
//   the pipeline is empty.
//   Throughput is one beat per cycle while the receiver takes results; the
//   stage depth is set by one multiply of at most 27x25 bits or one short
//   multi-operand wide sum and compare per stage.
//   Reset clears all stage valid bits and loads the half sizes with 0.5 and
//   the tolerance with 0. When the receiver stalls, every stage holds and
//   in_ready_o drops, so no beat is lost or repeated.
module triangle_box_overlap_test
  import tbo_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]            cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [CoordW-1:0]   center_x_i,
  input  logic signed [CoordW-1:0]   center_y_i,
  input  logic signed [CoordW-1:0]   center_z_i,
  input  logic signed [CoordW-1:0]   vert0_x_i,
  input  logic signed [CoordW-1:0]   vert0_y_i,
  input  logic signed [CoordW-1:0]   vert0_z_i,
  input  logic signed [CoordW-1:0]   vert1_x_i,
  input  logic signed [CoordW-1:0]   vert1_y_i,
  input  logic signed [CoordW-1:0]   vert1_z_i,
  input  logic signed [CoordW-1:0]   vert2_x_i,
  input  logic signed [CoordW-1:0]   vert2_y_i,
  input  logic signed [CoordW-1:0]   vert2_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       overlaps_o
);

  localparam int NumStages = 7;

  logic [HalfW-1:0] half_q [3];
  logic [TolW-1:0]  tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= HalfW'(2048);
      half_q[1] <= HalfW'(2048);
      half_q[2] <= HalfW'(2048);
      tol_q     <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HALF_X: half_q[0] <= cfg_data_i[HalfW-1:0];
        REG_HALF_Y: half_q[1] <= cfg_data_i[HalfW-1:0];
        REG_HALF_Z: half_q[2] <= cfg_data_i[HalfW-1:0];
        REG_TOL:    tol_q     <= cfg_data_i[TolW-1:0];
        default:    ;
      endcase
    end
  end

  // One stall signal holds every stage.
  logic [NumStages-1:0] vld_q;
  logic                 adv;

  assign adv         = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: translate vertices, form edges.
  logic signed [CoordW-1:0] vin [3][3];
  logic signed [CoordW-1:0] cin [3];
  logic signed [VecW-1:0]   v_q [3][3];
  logic signed [VecW-1:0]   e_q [3][3];

  assign cin[0] = center_x_i;
  assign cin[1] = center_y_i;
  assign cin[2] = center_z_i;
  assign vin[0][0] = vert0_x_i;
  assign vin[0][1] = vert0_y_i;
  assign vin[0][2] = vert0_z_i;
  assign vin[1][0] = vert1_x_i;
  assign vin[1][1] = vert1_y_i;
  assign vin[1][2] = vert1_z_i;
  assign vin[2][0] = vert2_x_i;
  assign vin[2][1] = vert2_y_i;
  assign vin[2][2] = vert2_z_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int a = 0; a < 3; a++) begin
          v_q[k][a] <= VecW'(vin[k][a]) - VecW'(cin[a]);
          e_q[k][a] <= VecW'(vin[(k + 1) % 3][a]) - VecW'(vin[k][a]);
        end
      end
    end
  end

  // Stage 2: edge-axis products, normal products, box-axis extents.
  logic signed [ProdW-1:0] ta_q [NumEdgeTests];
  logic signed [ProdW-1:0] tb_q [NumEdgeTests];
  logic signed [ProdW-1:0] tc_q [NumEdgeTests];
  logic signed [ProdW-1:0] td_q [NumEdgeTests];
  logic [ProdW-1:0]        ra_q [NumEdgeTests];
  logic [ProdW-1:0]        rb_q [NumEdgeTests];
  logic signed [ProdW-1:0] np_q [3];
  logic signed [ProdW-1:0] nm_q [3];
  logic signed [VecW-1:0]  v0s2_q [3];
  logic                    box_s2_q;
  logic [2:0]              box_ok;

  for (genvar g = 0; g < NumEdgeTests; g++) begin : g_edge_mul
    localparam int EI = EdgeSel[g];
    localparam int UA = (AxisSel[g] + 1) % 3;
    localparam int WA = (AxisSel[g] + 2) % 3;
    localparam int IA = VertA[g];
    localparam int IB = VertB[g];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ta_q[g] <= ProdW'(e_q[EI][WA] * v_q[IA][UA]);
        tb_q[g] <= ProdW'(e_q[EI][UA] * v_q[IA][WA]);
        tc_q[g] <= ProdW'(e_q[EI][WA] * v_q[IB][UA]);
        td_q[g] <= ProdW'(e_q[EI][UA] * v_q[IB][WA]);
        ra_q[g] <= ProdW'(mag_vec(e_q[EI][WA]) * half_q[UA]);
        rb_q[g] <= ProdW'(mag_vec(e_q[EI][UA]) * half_q[WA]);
      end
    end
  end

  always_comb begin
    logic signed [VecW:0] hp;
    logic signed [VecW:0] hn;
    logic                 all_hi;
    logic                 all_lo;
    for (int a = 0; a < 3; a++) begin
      hp = $signed({3'b000, half_q[a]});
      hn = -hp;
      all_hi = 1'b1;
      all_lo = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (!((VecW+1)'(v_q[k][a]) > hp)) all_hi = 1'b0;
        if (!((VecW+1)'(v_q[k][a]) < hn)) all_lo = 1'b0;
      end
      box_ok[a] = !(all_hi || all_lo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        np_q[a]   <= ProdW'(e_q[0][(a + 1) % 3] * e_q[1][(a + 2) % 3]);
        nm_q[a]   <= ProdW'(e_q[0][(a + 2) % 3] * e_q[1][(a + 1) % 3]);
        v0s2_q[a] <= v_q[0][a];
      end
      box_s2_q <= &box_ok;
    end
  end

  // Stage 3: edge-axis compares, normal components.
  logic [NumEdgeTests-1:0] edge_ok;
  logic                    hit_s3_q;
  logic signed [NrmW-1:0]  n_q [3];
  logic signed [VecW-1:0]  v0s3_q [3];

  for (genvar g = 0; g < NumEdgeTests; g++) begin : g_edge_cmp
    logic signed [CmpW-1:0] p0;
    logic signed [CmpW-1:0] p1;
    logic signed [CmpW-1:0] rad;
    logic signed [CmpW-1:0] nrad;
    assign p0   = CmpW'(ta_q[g]) - CmpW'(tb_q[g]);
    assign p1   = CmpW'(tc_q[g]) - CmpW'(td_q[g]);
    assign rad  = $signed(CmpW'(ra_q[g]) + CmpW'(rb_q[g]) + (CmpW'(tol_q) << 12));
    assign nrad = -rad;
    assign edge_ok[g] = !((p0 > rad && p1 > rad) || (p0 < nrad && p1 < nrad));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_s3_q <= box_s2_q && (&edge_ok);
      for (int a = 0; a < 3; a++) begin
        n_q[a]    <= NrmW'(np_q[a]) - NrmW'(nm_q[a]);
        v0s3_q[a] <= v0s2_q[a];
      end
    end
  end

  // Stage 4: split products n.v0 and n*h (normal cut into high and low parts).
  localparam int NrmHiW = NrmW - NrmLoW;
  logic signed [ProdW-1:0]   dh_q [3];
  logic signed [ProdW+1:0]   dl_q [3];
  logic signed [ProdW-1:0]   rh_q [3];
  logic signed [ProdW-1:0]   rl_q [3];
  logic                      hit_s4_q;

  always_ff @(posedge clk_i) begin
    logic signed [NrmHiW-1:0] nh;
    logic signed [NrmLoW:0]   nl;
    logic signed [HalfW:0]    hs;
    if (adv) begin
      hit_s4_q <= hit_s3_q;
      for (int a = 0; a < 3; a++) begin
        nh = n_q[a][NrmW-1:NrmLoW];
        nl = $signed({1'b0, n_q[a][NrmLoW-1:0]});
        hs = $signed({1'b0, half_q[a]});
        dh_q[a] <= ProdW'(nh * v0s3_q[a]);
        dl_q[a] <= (ProdW+2)'(nl * v0s3_q[a]);
        rh_q[a] <= ProdW'(nh * hs);
        rl_q[a] <= ProdW'(nl * hs);
      end
    end
  end

  // Stage 5: recombine; d summed, n_i*h_i kept per component.
  logic signed [WideW-1:0] d5_q;
  logic signed [WideW-1:0] rc_q [3];
  logic                    hit_s5_q;

  always_ff @(posedge clk_i) begin
    logic signed [WideW-1:0] acc;
    if (adv) begin
      hit_s5_q <= hit_s4_q;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
        acc = acc + (WideW'(dh_q[a]) <<< NrmLoW) + WideW'(dl_q[a]);
        rc_q[a] <= (WideW'(rh_q[a]) <<< NrmLoW) + WideW'(rl_q[a]);
      end
      d5_q <= acc;
    end
  end

  // Stage 6: radius of the box projected on the normal.
  logic signed [WideW-1:0] d6_q;
  logic signed [WideW-1:0] r6_q;
  logic                    hit_s6_q;

  always_ff @(posedge clk_i) begin
    logic signed [WideW-1:0] acc;
    if (adv) begin
      hit_s6_q <= hit_s5_q;
      acc = '0;
      for (int a = 0; a < 3; a++) begin
        acc = acc + (rc_q[a][WideW-1] ? -rc_q[a] : rc_q[a]);
      end
      r6_q <= acc;
      d6_q <= d5_q;
    end
  end

  // Stage 7: plane test, -R <= d <= R, and the output register.
  logic signed [WideW-1:0] sum_pos;
  logic signed [WideW-1:0] sum_neg;
  logic                    ovl_q;

  assign sum_pos = r6_q + d6_q;
  assign sum_neg = r6_q - d6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ovl_q <= hit_s6_q && !sum_pos[WideW-1] && !sum_neg[WideW-1];
    end
  end

  assign overlaps_o = ovl_q;

endmodule

// ----- test/tb_triangle_box_overlap_test.sv -----
// Self-checking testbench for triangle_box_overlap_test: streams triangle/box
// pairs under random backpressure and compares each overlap bit with an exact
// integer separating-axis predictor. Depends on tbo_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_triangle_box_overlap_test;
  import tbo_pkg::*;

  typedef struct {
    logic signed [CoordW-1:0] ctr[3];
    logic signed [CoordW-1:0] vtx[3][3];
  } tri_box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CoordW-1:0] ctr_s[3];
  logic signed [CoordW-1:0] vtx_s[3][3];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic overlaps_o;

  // Shadow copy of the box registers, used by the predictor.
  longint half_ext[3] = '{2048, 2048, 2048};
  longint slack = 0;

  bit overlap_q[$];
  int mismatches = 0;
  int checked = 0;
  int hits = 0;
  int send_idle_pct = 32;
  int sink_idle_pct = 32;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk_i = ~clk_i;

  triangle_box_overlap_test dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .center_x_i(ctr_s[0]), .center_y_i(ctr_s[1]), .center_z_i(ctr_s[2]),
    .vert0_x_i(vtx_s[0][0]), .vert0_y_i(vtx_s[0][1]), .vert0_z_i(vtx_s[0][2]),
    .vert1_x_i(vtx_s[1][0]), .vert1_y_i(vtx_s[1][1]), .vert1_z_i(vtx_s[1][2]),
    .vert2_x_i(vtx_s[2][0]), .vert2_y_i(vtx_s[2][1]), .vert2_z_i(vtx_s[2][2]),
    .out_valid_o, .out_ready_i, .overlaps_o
  );

  function automatic longint mag_of(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Exact separating-axis test; products fit in 64 bits except the plane
  // test, which is carried in 128 bits.
  function automatic bit predict_overlap(tri_box_t t);
    longint v[3][3], e[3][3], n[3];
    longint p0, p1, lo, hi, rad;
    logic signed [127:0] d, r;
    int u, w, ei, k, ia, ib;
    bit hit;
    hit = 1'b1;
    for (int q = 0; q < 3; q++)
      for (int a = 0; a < 3; a++)
        v[q][a] = longint'(t.vtx[q][a]) - longint'(t.ctr[a]);
    for (int a = 0; a < 3; a++) begin
      e[0][a] = v[1][a] - v[0][a];
      e[1][a] = v[2][a] - v[1][a];
      e[2][a] = v[0][a] - v[2][a];
    end
    for (int s = 0; s < NumEdgeTests; s++) begin
      ei = EdgeSel[s]; k = AxisSel[s]; ia = VertA[s]; ib = VertB[s];
      u = (k + 1) % 3; w = (k + 2) % 3;
      p0 = e[ei][w] * v[ia][u] - e[ei][u] * v[ia][w];
      p1 = e[ei][w] * v[ib][u] - e[ei][u] * v[ib][w];
      lo = (p0 < p1) ? p0 : p1;
      hi = (p0 < p1) ? p1 : p0;
      rad = mag_of(e[ei][w]) * half_ext[u] + mag_of(e[ei][u]) * half_ext[w]
            + (slack << 12);
      if (lo > rad || hi < -rad) hit = 1'b0;
    end
    for (int a = 0; a < 3; a++) begin
      lo = v[0][a]; hi = v[0][a];
      for (int q = 1; q < 3; q++) begin
        if (v[q][a] < lo) lo = v[q][a];
        if (v[q][a] > hi) hi = v[q][a];
      end
      if (lo > half_ext[a] || hi < -half_ext[a]) hit = 1'b0;
    end
    n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
    n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
    n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    d = '0; r = '0;
    for (int a = 0; a < 3; a++) begin
      d += 128'(signed'(n[a])) * 128'(signed'(v[0][a]));
      r += 128'(signed'(mag_of(n[a]))) * 128'(signed'(half_ext[a]));
    end
    if (d > r || d < -r) hit = 1'b0;
    return hit;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] data);
    // The last beat was accepted at this edge; stop offering it again.
    in_valid_i <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HALF_X: half_ext[0] = data[HalfW-1:0];
      REG_HALF_Y: half_ext[1] = data[HalfW-1:0];
      REG_HALF_Z: half_ext[2] = data[HalfW-1:0];
      REG_TOL:    slack = data[TolW-1:0];
      default:    ;
    endcase
  endtask

  task automatic set_box(logic [CfgW-1:0] hx, logic [CfgW-1:0] hy,
                         logic [CfgW-1:0] hz, logic [CfgW-1:0] tol);
    write_reg(REG_HALF_X, hx);
    write_reg(REG_HALF_Y, hy);
    write_reg(REG_HALF_Z, hz);
    write_reg(REG_TOL, tol);
  endtask

  // Sends one beat; valid is only lowered when the sender idles.
  task automatic send_pair(tri_box_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ctr_s <= t.ctr;
    vtx_s <= t.vtx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    overlap_q.push_back(predict_overlap(t));
  endtask

  function automatic logic signed [CoordW-1:0] clip(longint x);
    if (x > 8388607) return 24'sd8388607;
    if (x < -8388608) return -24'sd8388608;
    return CoordW'(x);
  endfunction

  // Mostly triangles near the box so both outcomes are common.
  function automatic tri_box_t rand_pair();
    tri_box_t t;
    longint span;
    int mode;
    mode = $urandom_range(9);
    for (int a = 0; a < 3; a++) t.ctr[a] = CoordW'($urandom);
    for (int q = 0; q < 3; q++)
      for (int a = 0; a < 3; a++) begin
        span = 3 * half_ext[a] + 64;
        if (mode < 2) t.vtx[q][a] = CoordW'($urandom);
        else t.vtx[q][a] = clip(longint'(t.ctr[a]) +
                                longint'($urandom_range(0, 2 * span)) - span);
      end
    return t;
  endfunction

  function automatic tri_box_t flat_pair(longint c, longint v0, longint v1,
                                         longint v2);
    tri_box_t t;
    for (int a = 0; a < 3; a++) begin
      t.ctr[a] = clip(c);
      t.vtx[0][a] = clip(v0); t.vtx[1][a] = clip(v1); t.vtx[2][a] = clip(v2);
    end
    return t;
  endfunction

  task automatic test_directed();
    tri_box_t t;
    send_pair(flat_pair(8388607, 8388607, 8388607, 8388607));
    send_pair(flat_pair(-8388608, -8388608, -8388608, -8388608));
    send_pair(flat_pair(-8388608, 8388607, 8388607, -8388608));
    send_pair(flat_pair(8388607, -8388608, 8388607, -8388608));
    send_pair(flat_pair(0, 5000, 5000, 5000));
    send_pair(flat_pair(0, 1000, 1000, 1000));
    // Degenerate triangle on a line through the box.
    send_pair(flat_pair(0, -3000, 0, 3000));
    // Touching exactly at a face and just missing it.
    t = flat_pair(0, 0, 0, 0);
    t.vtx[0][0] = 2048; t.vtx[1][0] = 4096; t.vtx[2][0] = 4096;
    t.vtx[1][1] = 100; t.vtx[2][2] = 100;
    send_pair(t);
    t.vtx[0][0] = 2049;
    send_pair(t);
    // Large triangle enclosing the box, plane passing through it.
    t = flat_pair(0, 0, 0, 0);
    t.vtx[0] = '{-100000, -100000, 0};
    t.vtx[1] = '{100000, -100000, 0};
    t.vtx[2] = '{0, 100000, 0};
    send_pair(t);
    t.vtx[0][2] = 2048; t.vtx[1][2] = 2048; t.vtx[2][2] = 2048;
    send_pair(t);
    t.vtx[0][2] = 2049; t.vtx[1][2] = 2049; t.vtx[2][2] = 2049;
    send_pair(t);
    // Plane tilted past a corner.
    t.vtx[0] = '{12000, 0, 0};
    t.vtx[1] = '{0, 12000, 0};
    t.vtx[2] = '{0, 0, 12000};
    send_pair(t);
    for (int q = 0; q < 3; q++) t.vtx[q][q] = 6144;
    send_pair(t);
    for (int q = 0; q < 3; q++) t.vtx[q][q] = 6145;
    send_pair(t);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(rand_pair());
  endtask

  task automatic test_back_to_back(int count);
    send_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(count);
    send_idle_pct = 32;
    sink_idle_pct = 32;
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    hold_requests++;
    test_random(40);
    send_idle_pct = 32;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= 200;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (overlap_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        bit want;
        want = overlap_q.pop_front();
        checked++;
        if (want) hits++;
        if (overlaps_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("overlap mismatch: expected %0d, got %0b", want, overlaps_o);
        end
      end
    end
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      ctr_s[a] = '0;
      for (int q = 0; q < 3; q++) vtx_s[q][a] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    set_box(8388607, 8388607, 8388607, {11'h7FF, 12'hFFF});
    test_directed();
    test_random(150);
    set_box(0, 0, 0, 0);
    test_directed();
    test_random(150);
    set_box(4096, 300, 20000, 4095);
    test_back_to_back(150);
    test_output_hold();
    test_random(150);
    set_box(1, 70000, 12, 7);
    test_random(150);
    for (int p = 0; p < 3; p++) begin
      set_box(CfgW'($urandom_range(0, 100000)), CfgW'($urandom_range(0, 100000)),
              CfgW'($urandom_range(0, 100000)), CfgW'($urandom));
      test_random(80);
    end
    in_valid_i <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d overlap results (%0d overlapping) over 8 box settings,",
             checked, hits);
    $display("including extremes, touching cases, back-to-back and a long output stall.");
    if (mismatches == 0 && overlap_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tbo_pkg.sv
rtl/triangle_box_overlap_test.sv
test/tb_triangle_box_overlap_test.sv
